// ===== hdl/s1sh_pkg.sv =====
// Shared types and constants for the SHA-1 stream hasher.
package s1sh_pkg;

  localparam int CHAIN_DEPTH     = 5;
  localparam int WORDS_PER_BLOCK = 16;
  localparam int ROUNDS          = 80;
  localparam int LEN_OFFSET      = 56;
  localparam int LAST_BYTE       = 63;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK = 8'h80;

  // Control from the sequencer to the round datapath
  typedef struct packed {
    logic        w_shift;   // shift a loaded message word into the schedule
    logic [31:0] w_word;
    logic        wk_load;   // load one working variable from the chain
    logic [2:0]  wk_idx;
    logic [31:0] wk_word;
    logic        round_en;  // run one round
    logic [6:0]  rnd;
  } s1sh_ctl_t;

  function automatic logic [31:0] s1sh_iv(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = IV0;
      3'd1:    v = IV1;
      3'd2:    v = IV2;
      3'd3:    v = IV3;
      default: v = IV4;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/s1sh_round_core.sv =====
// Round datapath: message schedule window and the five working variables.
module s1sh_round_core import s1sh_pkg::*; (
  input  logic        clk,
  input  s1sh_ctl_t   ctl,
  output logic [31:0] wk_o [CHAIN_DEPTH]
);

  logic [31:0] sched_r [WORDS_PER_BLOCK];
  logic [31:0] wk_r [CHAIN_DEPTH];
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] t;
  logic [31:0] w_mix;
  logic [31:0] w_next;

  always_comb begin
    if (ctl.rnd < 7'd20) begin
      f = (wk_r[1] & wk_r[2]) | (~wk_r[1] & wk_r[3]);
      k = K0;
    end else if (ctl.rnd < 7'd40) begin
      f = wk_r[1] ^ wk_r[2] ^ wk_r[3];
      k = K1;
    end else if (ctl.rnd < 7'd60) begin
      f = (wk_r[1] & wk_r[2]) | (wk_r[1] & wk_r[3]) | (wk_r[2] & wk_r[3]);
      k = K2;
    end else begin
      f = wk_r[1] ^ wk_r[2] ^ wk_r[3];
      k = K3;
    end
    t      = {wk_r[0][26:0], wk_r[0][31:27]} + f + wk_r[4] + k + sched_r[0];
    w_mix  = sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0];
    w_next = {w_mix[30:0], w_mix[31]};
  end

  // Advance the schedule window on every load or round; load or update the working variables
  always_ff @(posedge clk) begin
    if (ctl.w_shift || ctl.round_en) begin
      for (int i = 0; i < WORDS_PER_BLOCK - 1; i++) begin
        sched_r[i] <= sched_r[i+1];
      end
      sched_r[WORDS_PER_BLOCK-1] <= ctl.w_shift ? ctl.w_word : w_next;
    end
    if (ctl.wk_load) begin
      wk_r[ctl.wk_idx] <= ctl.wk_word;
    end else if (ctl.round_en) begin
      wk_r[0] <= t;
      wk_r[1] <= wk_r[0];
      wk_r[2] <= {wk_r[1][1:0], wk_r[1][31:2]};
      wk_r[3] <= wk_r[2];
      wk_r[4] <= wk_r[3];
    end
  end

  assign wk_o = wk_r;

endmodule

// ===== hdl/sha1_stream_hasher.sv =====
// Top level of the SHA-1 stream hasher: byte intake, padding, block sequencer, digest output.
// Intake: while idle, a byte without a block boundary is taken; the 64th byte of a block starts a
// compression (block loads, 80 rounds, chain write-back) while input is held off.
// End of message adds one or two padded compressions, then five digest words, each read from
// the chain and registered when the consumer is ready. The datapath runs one round per cycle.
// Reset (sync, active low) clears control, byte count and chain valid flags, not block memory.
module sha1_stream_hasher import s1sh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  // input request channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // end_of_message
  // digest channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic        out_tlast   // last_word
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_WBACK,
    ST_OUT_RD,
    ST_OUT_WR
  } state_t;

  // what the block in the buffer memory holds for the next compression
  typedef enum logic [1:0] {
    BLK_DATA,   // a full block of message bytes
    BLK_PAD1,   // message tail with padding, length if it fits
    BLK_PAD2    // zeros and the length only
  } blk_kind_t;

  // control state
  state_t                 state_r;
  blk_kind_t              kind_r;
  logic [60:0]            count_r;
  logic                   eom_pend_r;
  logic [4:0]             ld_r;
  logic [6:0]             rnd_r;
  logic [2:0]             wb_r;
  logic [2:0]             out_idx_r;
  logic                   out_tvalid_r;
  logic [CHAIN_DEPTH-1:0] cv_r;

  // payload
  logic [31:0] acc_r;
  logic [31:0] out_tdata_r;
  logic        out_tlast_r;

  // block buffer memory: 16 big-endian words
  logic [31:0] buf_mem [WORDS_PER_BLOCK];
  logic [31:0] buf_rd_r;
  logic [3:0]  buf_ridx_r;
  logic        buf_we;
  logic [3:0]  buf_waddr;
  logic [31:0] buf_wdata;
  logic [3:0]  buf_raddr;

  // chain memory: H0..H4, entries without a valid flag read as the initial values
  logic [31:0] chain_mem [CHAIN_DEPTH];
  logic [31:0] chain_rd_r;
  logic [2:0]  chain_ridx_r;
  logic        chain_rdv_r;
  logic        chain_re;
  logic [2:0]  chain_raddr;
  logic        chain_we;
  logic [2:0]  chain_waddr;
  logic [31:0] chain_wdata;
  logic [31:0] chain_val;

  logic        in_fire;
  logic [5:0]  tail;
  logic [63:0] bit_len;
  logic        out_go;
  logic [31:0] pad_word;
  logic [31:0] wk [CHAIN_DEPTH];
  s1sh_ctl_t   ctl;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign tail       = count_r[5:0];
  assign bit_len    = {count_r, 3'b000};
  assign out_go     = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  assign chain_val = chain_rdv_r ? chain_rd_r : s1sh_iv(chain_ridx_r);

  // Build the schedule word for the last buffer read: message bytes, the pad mark,
  // zeros and the big-endian bit length, depending on the block kind.
  always_comb begin
    logic [5:0] p;
    logic [7:0] mem_b;
    logic [7:0] src_b;
    logic [7:0] len_b;
    logic [7:0] b;
    pad_word = '0;
    for (int k = 0; k < 4; k++) begin
      p     = {buf_ridx_r, 2'(k)};
      mem_b = buf_rd_r[8*(3-k) +: 8];
      src_b = (buf_ridx_r == tail[5:2]) ? acc_r[8*(3-k) +: 8] : mem_b;
      len_b = bit_len[{~p[2:0], 3'b000} +: 8];
      case (kind_r)
        BLK_DATA: begin
          b = mem_b;
        end
        BLK_PAD1: begin
          if (p < tail) begin
            b = src_b;
          end else if (p == tail) begin
            b = PAD_MARK;
          end else begin
            b = 8'h00;
          end
          if (tail < 6'(LEN_OFFSET) && p >= 6'(LEN_OFFSET)) begin
            b = len_b;
          end
        end
        BLK_PAD2: begin
          b = (p >= 6'(LEN_OFFSET)) ? len_b : 8'h00;
        end
        default: begin
          b = 8'h00;
        end
      endcase
      pad_word[8*(3-k) +: 8] = b;
    end
  end

  // Memory ports
  always_comb begin
    buf_we    = in_fire && in_tuser && (tail[1:0] == 2'd3);
    buf_waddr = tail[5:2];
    buf_wdata = {acc_r[31:8], in_tdata};
    buf_raddr = ld_r[3:0];

    chain_re    = 1'b0;
    chain_raddr = '0;
    case (state_r)
      ST_LOAD: begin
        chain_re    = (ld_r < 5'(CHAIN_DEPTH));
        chain_raddr = ld_r[2:0];
      end
      ST_WBACK: begin
        chain_re    = (wb_r < 3'(CHAIN_DEPTH));
        chain_raddr = wb_r;
      end
      ST_OUT_RD: begin
        chain_re    = out_go;
        chain_raddr = out_idx_r;
      end
      default: begin
        chain_re = 1'b0;
      end
    endcase

    // write back H[j] + working variable j, one entry behind the read
    chain_we    = (state_r == ST_WBACK) && (wb_r != 3'd0);
    chain_waddr = wb_r - 3'd1;
    chain_wdata = chain_val + wk[chain_waddr];
  end

  // Round datapath control
  always_comb begin
    ctl.w_shift  = (state_r == ST_LOAD) && (ld_r != 5'd0);
    ctl.w_word   = pad_word;
    ctl.wk_load  = (state_r == ST_LOAD) && (ld_r != 5'd0) && (ld_r <= 5'(CHAIN_DEPTH));
    ctl.wk_idx   = ld_r[2:0] - 3'd1;
    ctl.wk_word  = chain_val;
    ctl.round_en = (state_r == ST_ROUND);
    ctl.rnd      = rnd_r;
  end

  s1sh_round_core u_core (
    .clk  (clk),
    .ctl  (ctl),
    .wk_o (wk)
  );

  always_ff @(posedge clk) begin
    if (buf_we) begin
      buf_mem[buf_waddr] <= buf_wdata;
    end
    buf_rd_r   <= buf_mem[buf_raddr];
    buf_ridx_r <= buf_raddr;
  end

  always_ff @(posedge clk) begin
    if (chain_we) begin
      chain_mem[chain_waddr] <= chain_wdata;
    end
    if (chain_re) begin
      chain_rd_r   <= chain_mem[chain_raddr];
      chain_ridx_r <= chain_raddr;
      chain_rdv_r  <= cv_r[chain_raddr];
    end
  end

  // Payload: partial word of the tail and the output register
  always_ff @(posedge clk) begin
    if (in_fire && in_tuser) begin
      acc_r[{~tail[1:0], 3'b000} +: 8] <= in_tdata;
    end
    if (state_r == ST_OUT_WR) begin
      out_tdata_r <= chain_val;
      out_tlast_r <= (out_idx_r == 3'(CHAIN_DEPTH - 1));
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      kind_r       <= BLK_DATA;
      count_r      <= '0;
      eom_pend_r   <= 1'b0;
      ld_r         <= '0;
      rnd_r        <= '0;
      wb_r         <= '0;
      out_idx_r    <= '0;
      out_tvalid_r <= 1'b0;
      cv_r         <= '0;
    end else begin
      // drop the output word once taken
      if (out_tvalid_r && out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      if (chain_we) begin
        cv_r[chain_waddr] <= 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_tuser) begin
              count_r <= count_r + 61'd1;
            end
            if (in_tuser && tail == 6'(LAST_BYTE)) begin
              // block full: compress it, pad afterwards if this ends the message
              kind_r     <= BLK_DATA;
              eom_pend_r <= in_tlast;
              ld_r       <= '0;
              state_r    <= ST_LOAD;
            end else if (in_tlast) begin
              kind_r  <= BLK_PAD1;
              ld_r    <= '0;
              state_r <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          ld_r <= ld_r + 5'd1;
          if (ld_r == 5'(WORDS_PER_BLOCK)) begin
            rnd_r   <= '0;
            state_r <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          rnd_r <= rnd_r + 7'd1;
          if (rnd_r == 7'(ROUNDS - 1)) begin
            wb_r    <= '0;
            state_r <= ST_WBACK;
          end
        end
        ST_WBACK: begin
          wb_r <= wb_r + 3'd1;
          if (wb_r == 3'(CHAIN_DEPTH)) begin
            ld_r      <= '0;
            out_idx_r <= '0;
            case (kind_r)
              BLK_DATA: begin
                if (eom_pend_r) begin
                  eom_pend_r <= 1'b0;
                  kind_r     <= BLK_PAD1;
                  state_r    <= ST_LOAD;
                end else begin
                  state_r <= ST_IDLE;
                end
              end
              BLK_PAD1: begin
                if (tail >= 6'(LEN_OFFSET)) begin
                  kind_r  <= BLK_PAD2;
                  state_r <= ST_LOAD;
                end else begin
                  state_r <= ST_OUT_RD;
                end
              end
              default: begin
                state_r <= ST_OUT_RD;
              end
            endcase
          end
        end
        ST_OUT_RD: begin
          // hold until the output register is free at this edge
          if (out_go) begin
            state_r <= ST_OUT_WR;
          end
        end
        ST_OUT_WR: begin
          out_tvalid_r <= 1'b1;
          if (out_idx_r == 3'(CHAIN_DEPTH - 1)) begin
            // digest done: back to the initial chain and an empty message
            cv_r    <= '0;
            count_r <= '0;
            state_r <= ST_IDLE;
          end else begin
            out_idx_r <= out_idx_r + 3'd1;
            state_r   <= ST_OUT_RD;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
